// ===== rtl/esvt_pkg.sv =====
// Shared constants and types for the eased sprite vertex transform.
package esvt_pkg;

   localparam int ANGLE_TABLE_BITS = 10;
   localparam int PHASE_W = ANGLE_TABLE_BITS + 2;
   localparam int SIN_LAT = 7;
   localparam int DIV_STEPS = 16;

   localparam logic [PHASE_W-1:0] QUARTER_PHASE = PHASE_W'(1 << ANGLE_TABLE_BITS);

   localparam logic [2:0] CSR_DURATION = 3'd0;
   localparam logic [2:0] CSR_MODE     = 3'd1;
   localparam logic [2:0] CSR_SHIFT_X  = 3'd2;
   localparam logic [2:0] CSR_SHIFT_Y  = 3'd3;
   localparam logic [2:0] CSR_ZOOM     = 3'd4;
   localparam logic [2:0] CSR_SPIN     = 3'd5;
   localparam logic [2:0] CSR_FADE     = 3'd6;
   localparam logic [2:0] CSR_CENTER   = 3'd7;

   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_COSINE = 2'd2;

   localparam logic [15:0] DURATION_RESET = 16'd1000;

   localparam logic [30:0] INV_PI_Q32 = 31'h517CC1B7;
   localparam logic [16:0] SIN_C1 = 17'd102954;
   localparam logic [15:0] SIN_C3 = 16'd42334;
   localparam logic [12:0] SIN_C5 = 13'd5223;
   localparam logic [8:0]  SIN_C7 = 9'd307;
   localparam logic [15:0] SIN_MAX = 16'd16384;

   localparam logic [16:0] W_ONE = 17'd65536;

   localparam logic signed [18:0] OUT_MAX = 19'sh3FFFF;
   localparam logic signed [18:0] OUT_MIN = 19'sh40000;

   typedef logic signed [15:0] trig_type;

endpackage

// ===== rtl/eased_sprite_vertex_transform.sv =====
// Top level of the eased sprite vertex transform pipeline.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_elapsed, req_vertex_x, req_vertex_y
//   rsp     | out       | rsp_valid / rsp_ready | rsp_out_x, rsp_out_y, rsp_out_alpha
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One word enters per cycle while req_ready is high.
// The 17-step restoring divider, the sine pipelines and the rotation multipliers set the depth.
// Reset restores the register defaults and empties the pipeline; csr_ready is always high.
// An output register and one skid word follow the pipeline; the pipeline and req_ready
// freeze only while the skid word is occupied.
module eased_sprite_vertex_transform import esvt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_elapsed,
   input  logic signed [13:0] req_vertex_x,
   input  logic signed [13:0] req_vertex_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_out_x,
   output logic signed [18:0] rsp_out_y,
   output logic [7:0]         rsp_out_alpha,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int B = ANGLE_TABLE_BITS;
   localparam int PIPE_DEPTH = 38;
   localparam int LAST = PIPE_DEPTH - 1;
   localparam int VX_STAGES = 32;
   localparam int PH_LSB = 59 - B;
   localparam int COS_LSB = 15 - B;
   localparam logic [17:0] COS_RND = 18'd1 << (14 - B);

   // Configuration registers.
   logic [15:0] duration_ff;
   logic [1:0]  mode_ff;
   logic [12:0] shift_x_ff;
   logic [12:0] shift_y_ff;
   logic [15:0] zoom_ff;
   logic [15:0] spin_ff;
   logic [8:0]  fade_ff;
   logic [31:0] center_ff;

   logic en;
   logic req_accept;
   logic [PIPE_DEPTH-1:0] vld_ff;

   // Divider.
   logic [15:0] dur_e;
   logic [15:0] t_cl;
   logic [15:0] num0;
   logic        ge0;
   logic [16:0] dbl  [1:DIV_STEPS];
   logic        ge_d [1:DIV_STEPS];
   logic [15:0] rem_in [1:DIV_STEPS-1];
   logic [15:0] rem_ff [0:DIV_STEPS-1];
   logic [16:0] quo_ff [0:DIV_STEPS];

   logic signed [13:0] vx_ff [0:VX_STAGES-1];
   logic signed [13:0] vy_ff [0:VX_STAGES-1];

   // Weight.
   logic [17:0]        cph_sum;
   logic [PHASE_W-1:0] cos_phase;
   trig_type           cos_w;
   logic [16:0]        mu_dly_ff [0:SIN_LAT-1];
   logic signed [17:0] cw;
   logic [16:0]        w_in;
   logic [16:0]        w_ff;
   logic [16:0]        wd_ff [0:10];

   // Angle.
   logic [15:0]        spin_mag;
   logic [31:0]        am_in;
   logic [31:0]        am_ff;
   logic [62:0]        ap_in;
   logic [62:0]        ap_ff;
   logic [63:0]        ph_sum;
   logic [PHASE_W-1:0] ph_raw;
   logic [PHASE_W-1:0] ang_in;
   logic [PHASE_W-1:0] ang_ff;
   logic [PHASE_W-1:0] ang_cos;
   trig_type           sn;
   trig_type           cs;

   // Position.
   logic [18:0]        cx;
   logic [18:0]        cy;
   logic [15:0]        zoom_mag;
   logic [16:0]        zsel;
   logic [31:0]        zp_in;
   logic [31:0]        zp_ff;
   logic signed [30:0] sxw_in;
   logic signed [30:0] syw_in;
   logic signed [30:0] sxw_ff;
   logic signed [30:0] syw_ff;
   logic signed [30:0] sxr;
   logic signed [30:0] syr;
   logic signed [16:0] vx8;
   logic signed [16:0] vy8;
   logic signed [21:0] px_in;
   logic signed [21:0] py_in;
   logic signed [21:0] px_ff;
   logic signed [21:0] py_ff;
   logic [32:0]        zr;
   logic [20:0]        z_in;
   logic [20:0]        z_ff;
   logic signed [43:0] zxp_in;
   logic signed [43:0] zyp_in;
   logic signed [43:0] zxp_ff;
   logic signed [43:0] zyp_ff;
   logic signed [43:0] zxr;
   logic signed [43:0] zyr;
   logic signed [23:0] zx_ff;
   logic signed [23:0] zy_ff;
   logic signed [39:0] pxc_ff;
   logic signed [39:0] pys_ff;
   logic signed [39:0] pxs_ff;
   logic signed [39:0] pyc_ff;
   logic signed [40:0] rxs;
   logic signed [40:0] rys;
   logic signed [25:0] rxr_ff;
   logic signed [25:0] ryr_ff;
   logic signed [26:0] rxf;
   logic signed [26:0] ryf;
   logic signed [18:0] fx_in;
   logic signed [18:0] fy_in;
   logic signed [18:0] fx_ff;
   logic signed [18:0] fy_ff;

   // Alpha.
   logic [8:0]  fade_mag;
   logic [16:0] fsel;
   logic [25:0] afp_in;
   logic [25:0] afp_ff;
   logic [26:0] ar;
   logic [10:0] red;
   logic [7:0]  fa_in;
   logic [7:0]  fa_ff;

   // Output register and skid word.
   logic               rsp_valid_ff;
   logic               skid_full_ff;
   logic signed [18:0] out_x_ff;
   logic signed [18:0] out_y_ff;
   logic [7:0]         out_a_ff;
   logic signed [18:0] skid_x_ff;
   logic signed [18:0] skid_y_ff;
   logic [7:0]         skid_a_ff;

   assign csr_ready  = 1'b1;
   assign en         = !skid_full_ff;
   assign req_ready  = en;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= DURATION_RESET;
         mode_ff     <= MODE_LINEAR;
         shift_x_ff  <= '0;
         shift_y_ff  <= '0;
         zoom_ff     <= '0;
         spin_ff     <= '0;
         fade_ff     <= '0;
         center_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DURATION: duration_ff <= csr_data[15:0];
            CSR_MODE:     mode_ff     <= csr_data[1:0];
            CSR_SHIFT_X:  shift_x_ff  <= csr_data[12:0];
            CSR_SHIFT_Y:  shift_y_ff  <= csr_data[12:0];
            CSR_ZOOM:     zoom_ff     <= csr_data[15:0];
            CSR_SPIN:     spin_ff     <= csr_data[15:0];
            CSR_FADE:     fade_ff     <= csr_data[8:0];
            CSR_CENTER:   center_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_accept};
      end
   end

   always_comb begin
      dur_e = (duration_ff == 16'd0) ? 16'd1 : duration_ff;
      t_cl  = (req_elapsed > dur_e) ? dur_e : req_elapsed;
      num0  = dur_e - t_cl;
      ge0   = num0 >= dur_e;
      for (int i = 1; i <= DIV_STEPS; i++) begin
         dbl[i]  = {rem_ff[i-1], 1'b0};
         ge_d[i] = dbl[i] >= {1'b0, dur_e};
      end
      for (int i = 1; i < DIV_STEPS; i++) begin
         rem_in[i] = ge_d[i] ? 16'(dbl[i] - {1'b0, dur_e}) : dbl[i][15:0];
      end
   end

   always_comb begin
      cph_sum   = {1'b0, quo_ff[DIV_STEPS]} + COS_RND;
      cos_phase = cph_sum[COS_LSB +: PHASE_W] + QUARTER_PHASE;
      cw        = 18'sd16384 - {{2{cos_w[15]}}, cos_w};
      case (mode_ff)
         MODE_LINEAR: w_in = mu_dly_ff[SIN_LAT-1];
         MODE_COSINE: w_in = {cw[15:0], 1'b0};
         default:     w_in = '0;
      endcase
   end

   always_comb begin
      spin_mag = spin_ff[15] ? (~spin_ff + 16'd1) : spin_ff;
      am_in    = spin_mag * w_ff;
      ap_in    = am_ff * INV_PI_Q32;
      ph_sum   = {1'b0, ap_ff} + (64'd1 << (PH_LSB - 1));
      ph_raw   = ph_sum[PH_LSB +: PHASE_W];
      ang_in   = spin_ff[15] ? (PHASE_W'(0) - ph_raw) : ph_raw;
      ang_cos  = ang_ff + QUARTER_PHASE;
   end

   always_comb begin
      cx       = {center_ff[15:0], 3'b000};
      cy       = {center_ff[31:16], 3'b000};
      zoom_mag = zoom_ff[15] ? (~zoom_ff + 16'd1) : zoom_ff;
      zsel     = zoom_ff[15] ? (W_ONE - wd_ff[5]) : wd_ff[5];
      zp_in    = zoom_mag * zsel;
      sxw_in   = $signed(shift_x_ff) * $signed({1'b0, wd_ff[5]});
      syw_in   = $signed(shift_y_ff) * $signed({1'b0, wd_ff[5]});
      sxr      = sxw_ff + 31'sd2048;
      syr      = syw_ff + 31'sd2048;
      vx8      = $signed({vx_ff[VX_STAGES-1], 3'b000});
      vy8      = $signed({vy_ff[VX_STAGES-1], 3'b000});
      px_in    = 22'(vx8) + 22'(sxr >>> 12) - $signed({3'b000, cx});
      py_in    = 22'(vy8) + 22'(syr >>> 12) - $signed({3'b000, cy});
      zr       = {1'b0, zp_ff} + 33'd2048;
      z_in     = 21'd65536 + zr[32:12];
      zxp_in   = px_ff * $signed({1'b0, z_ff});
      zyp_in   = py_ff * $signed({1'b0, z_ff});
      zxr      = zxp_ff + 44'sd32768;
      zyr      = zyp_ff + 44'sd32768;
      rxs      = 41'(pxc_ff) - 41'(pys_ff) + 41'sd8192;
      rys      = 41'(pxs_ff) + 41'(pyc_ff) + 41'sd8192;
      rxf      = 27'(rxr_ff) + $signed({8'b0, cx});
      ryf      = 27'(ryr_ff) + $signed({8'b0, cy});
      if (rxf > OUT_MAX) begin
         fx_in = OUT_MAX;
      end else if (rxf < OUT_MIN) begin
         fx_in = OUT_MIN;
      end else begin
         fx_in = rxf[18:0];
      end
      if (ryf > OUT_MAX) begin
         fy_in = OUT_MAX;
      end else if (ryf < OUT_MIN) begin
         fy_in = OUT_MIN;
      end else begin
         fy_in = ryf[18:0];
      end
   end

   always_comb begin
      fade_mag = fade_ff[8] ? (~fade_ff + 9'd1) : fade_ff;
      fsel     = fade_ff[8] ? (W_ONE - wd_ff[10]) : wd_ff[10];
      afp_in   = fade_mag * fsel;
      ar       = {1'b0, afp_ff} + 27'd32768;
      red      = ar[26:16];
      fa_in    = (red > 11'd255) ? 8'd0 : 8'(11'd255 - red);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ge0 ? 16'd0 : num0;
         quo_ff[0] <= {16'd0, ge0};
         for (int i = 1; i < DIV_STEPS; i++) begin
            rem_ff[i] <= rem_in[i];
         end
         for (int i = 1; i <= DIV_STEPS; i++) begin
            quo_ff[i] <= {quo_ff[i-1][15:0], ge_d[i]};
         end
         vx_ff[0] <= req_vertex_x;
         vy_ff[0] <= req_vertex_y;
         for (int i = 1; i < VX_STAGES; i++) begin
            vx_ff[i] <= vx_ff[i-1];
            vy_ff[i] <= vy_ff[i-1];
         end
         mu_dly_ff[0] <= quo_ff[DIV_STEPS];
         for (int i = 1; i < SIN_LAT; i++) begin
            mu_dly_ff[i] <= mu_dly_ff[i-1];
         end
         w_ff     <= w_in;
         wd_ff[0] <= w_ff;
         for (int i = 1; i < 11; i++) begin
            wd_ff[i] <= wd_ff[i-1];
         end
         am_ff  <= am_in;
         ap_ff  <= ap_in;
         ang_ff <= ang_in;
         zp_ff  <= zp_in;
         sxw_ff <= sxw_in;
         syw_ff <= syw_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         z_ff   <= z_in;
         zxp_ff <= zxp_in;
         zyp_ff <= zyp_in;
         zx_ff  <= zxr[39:16];
         zy_ff  <= zyr[39:16];
         pxc_ff <= zx_ff * cs;
         pys_ff <= zy_ff * sn;
         pxs_ff <= zx_ff * sn;
         pyc_ff <= zy_ff * cs;
         rxr_ff <= rxs[39:14];
         ryr_ff <= rys[39:14];
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         afp_ff <= afp_in;
         fa_ff  <= fa_in;
      end
   end

   esvt_sin u_cos_weight (
      .clock (clock),
      .en    (en),
      .phase (cos_phase),
      .value (cos_w)
   );

   esvt_sin u_sin_angle (
      .clock (clock),
      .en    (en),
      .phase (ang_ff),
      .value (sn)
   );

   esvt_sin u_cos_angle (
      .clock (clock),
      .en    (en),
      .phase (ang_cos),
      .value (cs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (vld_ff[LAST]) begin
         if (rsp_valid_ff && !rsp_ready) begin
            skid_full_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_ready) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
            out_a_ff <= skid_a_ff;
         end
      end else if (vld_ff[LAST]) begin
         if (rsp_valid_ff && !rsp_ready) begin
            skid_x_ff <= fx_ff;
            skid_y_ff <= fy_ff;
            skid_a_ff <= fa_ff;
         end else begin
            out_x_ff <= fx_ff;
            out_y_ff <= fy_ff;
            out_a_ff <= fa_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_alpha = out_a_ff;

`ifndef SYNTHESIS
   a_skid_needs_output: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid word held without a valid output word");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_valid_ff && !rsp_ready && vld_ff[LAST]))
      else $error("skid word filled without a stalled output");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |=> $stable(vld_ff))
      else $error("pipeline moved while the skid word was full");
`endif

endmodule

// ===== rtl/esvt_sin.sv =====
// Pipelined fixed-point sine of a phase, Q14 result, seven register stages.
module esvt_sin import esvt_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [PHASE_W-1:0] phase,
   output trig_type           value
);

   localparam int B = ANGLE_TABLE_BITS;
   localparam logic [B:0] QUARTER = {1'b1, {B{1'b0}}};

   logic [1:0]  quad_in;
   logic [B:0]  off_in;
   logic [16:0] x_in;
   logic [33:0] sq;
   logic [25:0] prod3;
   logic [29:0] prod4;
   logic [32:0] prod5;
   logic [33:0] prod6;
   logic [12:0] t1_in;
   logic [15:0] t2_in;
   logic [16:0] t3_in;
   logic [16:0] s_in;
   logic [17:0] sr;
   logic [15:0] sq_round;
   logic [14:0] mag;
   trig_type    value_in;

   logic [1:0]  quad_ff [0:5];
   logic [16:0] x_ff    [0:4];
   logic [16:0] x2_ff   [0:2];
   logic [12:0] t1_ff;
   logic [15:0] t2_ff;
   logic [16:0] t3_ff;
   logic [16:0] s_ff;
   trig_type    value_ff;

   always_comb begin
      quad_in = phase[B+1:B];
      off_in  = quad_in[0] ? (QUARTER - {1'b0, phase[B-1:0]}) : {1'b0, phase[B-1:0]};
      x_in    = {off_in, {(16-B){1'b0}}};
      sq      = x_ff[0] * x_ff[0];
      prod3   = x2_ff[0] * SIN_C7;
      t1_in   = SIN_C5 - {3'b000, prod3[25:16]};
      prod4   = x2_ff[1] * t1_ff;
      t2_in   = SIN_C3 - {2'b00, prod4[29:16]};
      prod5   = x2_ff[2] * t2_ff;
      t3_in   = SIN_C1 - prod5[32:16];
      prod6   = x_ff[4] * t3_ff;
      s_in    = prod6[32:16];
      sr      = {1'b0, s_ff} + 18'd2;
      sq_round = sr[17:2];
      mag     = (sq_round > SIN_MAX) ? SIN_MAX[14:0] : sq_round[14:0];
      value_in = quad_ff[5][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= quad_in;
         x_ff[0]    <= x_in;
         for (int i = 1; i < 6; i++) begin
            quad_ff[i] <= quad_ff[i-1];
         end
         for (int i = 1; i < 5; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         x2_ff[0] <= sq[32:16];
         x2_ff[1] <= x2_ff[0];
         x2_ff[2] <= x2_ff[1];
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         s_ff     <= s_in;
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== tb/sv/esvt_checker.sv =====
// Checker that predicts and compares every transformed vertex word of the block.
`timescale 1ns / 1ps

module esvt_checker import esvt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [15:0]        req_elapsed,
   input  logic signed [13:0] req_vertex_x,
   input  logic signed [13:0] req_vertex_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [18:0] rsp_out_x,
   input  logic signed [18:0] rsp_out_y,
   input  logic [7:0]         rsp_out_alpha,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic signed [18:0] x;
      logic signed [18:0] y;
      logic [7:0]         alpha;
   } vertex_word_type;

   vertex_word_type    vertex_q[$];

   logic [15:0]        duration_r;
   logic [1:0]         mode_r;
   logic signed [12:0] shift_x_r;
   logic signed [12:0] shift_y_r;
   logic signed [15:0] zoom_r;
   logic signed [15:0] spin_r;
   logic signed [8:0]  fade_r;
   logic [31:0]        center_r;

   function automatic longint sine_q14(logic [31:0] p);
      longint unsigned off, x, x2, t, s;
      logic [1:0] quad;
      quad = p[ANGLE_TABLE_BITS +: 2];
      off = p & ((64'd1 << ANGLE_TABLE_BITS) - 1);
      if (quad[0]) off = (64'd1 << ANGLE_TABLE_BITS) - off;
      x = (off << 16) >> ANGLE_TABLE_BITS;
      x2 = (x * x) >> 16;
      t = 64'd307;
      t = 64'd5223 - ((x2 * t) >> 16);
      t = 64'd42334 - ((x2 * t) >> 16);
      t = 64'd102954 - ((x2 * t) >> 16);
      s = (x * t) >> 16;
      s = (s + 2) >> 2;
      if (s > 16384) s = 16384;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic vertex_word_type transform_vertex(logic [15:0] elapsed,
                                                        logic signed [13:0] vx,
                                                        logic signed [13:0] vy);
      longint unsigned dur, t, mu, w, wsel, mag, z;
      logic [31:0] ph;
      longint px, py, zx, zy, sn, cs, rx, ry, alpha, cx, cy;
      vertex_word_type r;
      dur = (duration_r == 0) ? 64'd1 : 64'(duration_r);
      t = 64'(elapsed);
      if (t > dur) t = dur;
      mu = ((dur - t) << 16) / dur;
      w = 0;
      if (mode_r == MODE_LINEAR) begin
         w = mu;
      end else if (mode_r == MODE_COSINE) begin
         ph = 32'(((mu << (ANGLE_TABLE_BITS + 1)) + 32768) >> 16);
         w = 64'((16384 - sine_q14(ph + (32'd1 << ANGLE_TABLE_BITS))) * 2);
      end
      cx = longint'(center_r[15:0]) * 8;
      cy = longint'(center_r[31:16]) * 8;

      wsel = (zoom_r >= 0) ? w : 64'd65536 - w;
      mag = (zoom_r < 0) ? 64'(-longint'(zoom_r)) : 64'(zoom_r);
      z = 64'd65536 + ((mag * wsel + 2048) >> 12);

      mag = (spin_r < 0) ? 64'(-longint'(spin_r)) : 64'(spin_r);
      ph = 32'((mag * w * 64'h517CC1B7 + (64'd1 << (58 - ANGLE_TABLE_BITS)))
               >> (59 - ANGLE_TABLE_BITS));
      if (spin_r < 0) ph = 32'd0 - ph;
      sn = sine_q14(ph);
      cs = sine_q14(ph + (32'd1 << ANGLE_TABLE_BITS));

      px = longint'(vx) * 8 + round_shift(longint'(shift_x_r) * longint'(w), 12) - cx;
      py = longint'(vy) * 8 + round_shift(longint'(shift_y_r) * longint'(w), 12) - cy;
      zx = round_shift(px * longint'(z), 16);
      zy = round_shift(py * longint'(z), 16);
      rx = clamp(round_shift(zx * cs - zy * sn, 14) + cx, -262144, 262143);
      ry = clamp(round_shift(zx * sn + zy * cs, 14) + cy, -262144, 262143);

      wsel = (fade_r >= 0) ? w : 64'd65536 - w;
      mag = (fade_r < 0) ? 64'(-longint'(fade_r)) : 64'(fade_r);
      alpha = clamp(255 - longint'((mag * wsel + 32768) >> 16), 0, 255);

      r.x = 19'(rx);
      r.y = 19'(ry);
      r.alpha = 8'(alpha);
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      vertex_word_type e;
      if (reset) begin
         duration_r <= DURATION_RESET;
         mode_r <= MODE_LINEAR;
         shift_x_r <= '0;
         shift_y_r <= '0;
         zoom_r <= '0;
         spin_r <= '0;
         fade_r <= '0;
         center_r <= '0;
         vertex_q.delete();
      end else begin
         if (req_valid && req_ready)
            vertex_q.push_back(transform_vertex(req_elapsed, req_vertex_x, req_vertex_y));
         if (rsp_valid && rsp_ready) begin
            if (vertex_q.size() == 0) begin
               $error("result word with no expected vertex: x %0d y %0d alpha %0d",
                      rsp_out_x, rsp_out_y, rsp_out_alpha);
               fail_count++;
            end else begin
               e = vertex_q.pop_front();
               if (rsp_out_x !== e.x) begin
                  $error("out_x: expected %0d, actual %0d", e.x, rsp_out_x);
                  fail_count++;
               end
               if (rsp_out_y !== e.y) begin
                  $error("out_y: expected %0d, actual %0d", e.y, rsp_out_y);
                  fail_count++;
               end
               if (rsp_out_alpha !== e.alpha) begin
                  $error("out_alpha: expected %0d, actual %0d", e.alpha, rsp_out_alpha);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DURATION: duration_r <= csr_data[15:0];
               CSR_MODE:     mode_r <= csr_data[1:0];
               CSR_SHIFT_X:  shift_x_r <= csr_data[12:0];
               CSR_SHIFT_Y:  shift_y_r <= csr_data[12:0];
               CSR_ZOOM:     zoom_r <= csr_data[15:0];
               CSR_SPIN:     spin_r <= csr_data[15:0];
               CSR_FADE:     fade_r <= csr_data[8:0];
               CSR_CENTER:   center_r <= csr_data;
               default: ;
            endcase
         end
      end
      pending = vertex_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the testbench: clock, reset, stimulus, flow control and the verdict.
`timescale 1ns / 1ps

module tb_top import esvt_pkg::*; ();

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [15:0]        req_elapsed;
   logic signed [13:0] req_vertex_x;
   logic signed [13:0] req_vertex_y;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [18:0] rsp_out_x;
   logic signed [18:0] rsp_out_y;
   logic [7:0]         rsp_out_alpha;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   int                 fail_count;
   int                 pending;
   int                 cycles;
   bit                 send_fast;
   bit                 recv_fast;
   int                 words_taken;

   eased_sprite_vertex_transform dut (.*);

   esvt_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // The receiver stalls at random, with one long hold-off that fills the pipeline.
   initial begin
      int stall;
      bit ok;
      rsp_ready = 1'b0;
      words_taken = 0;
      recv_fast = 1'b0;
      @(negedge reset);
      forever begin
         if (words_taken % 128 == 0) recv_fast = ($urandom_range(0, 3) == 0);
         stall = recv_fast ? 0 : $urandom_range(0, 14);
         if (words_taken == 500) stall = 1000;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            ok = rsp_valid;
            @(posedge clock);
         end while (!ok);
         words_taken++;
      end
   end

   task automatic send_vertex(logic [15:0] elapsed, logic [13:0] vx, logic [13:0] vy);
      int gap;
      bit ok;
      gap = send_fast ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed <= elapsed;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] data);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic write_all(logic [15:0] dur, logic [1:0] mode, logic [12:0] sx,
                            logic [12:0] sy, logic [15:0] zm, logic [15:0] sp,
                            logic [8:0] fd, logic [31:0] ctr);
      drain();
      write_reg(CSR_DURATION, {$urandom} & 32'hFFFF0000 | dur);
      write_reg(CSR_MODE, {$urandom} & 32'hFFFFFFFC | mode);
      write_reg(CSR_SHIFT_X, 32'(sx));
      write_reg(CSR_SHIFT_Y, 32'(sy));
      write_reg(CSR_ZOOM, 32'(zm));
      write_reg(CSR_SPIN, 32'(sp));
      write_reg(CSR_FADE, 32'(fd));
      write_reg(CSR_CENTER, ctr);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, int width);
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         default: return 32'($urandom & ((64'd1 << width) - 1));
      endcase
   endfunction

   initial begin
      logic [15:0] dur;
      logic [15:0] el;
      int count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_elapsed = '0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_fast = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset: linear easing over 1000 ms.
      send_vertex(16'd0, 14'h2000, 14'h1FFF);
      send_vertex(16'd500, 14'h1FFF, 14'h2000);
      send_vertex(16'd1000, 14'h0000, 14'h0000);
      send_vertex(16'd1001, 14'h1FFF, 14'h1FFF);
      send_vertex(16'hFFFF, 14'h2000, 14'h2000);

      // Zero duration, spare mode, extreme offsets and a fade of minus 256.
      write_all(16'd0, MODE_SPARE, 13'h0FFF, 13'h1000, 16'h7FFF, 16'h8000, 9'h100,
                32'hFFFFFFFF);
      send_vertex(16'd0, 14'h1FFF, 14'h2000);
      send_vertex(16'd1, 14'h2000, 14'h1FFF);
      send_vertex(16'hFFFF, 14'h0000, 14'h0000);

      write_all(16'hFFFF, MODE_COSINE, 13'h1000, 13'h0FFF, 16'h8000, 16'h7FFF, 9'h0FF,
                32'h0000FFFF);
      send_vertex(16'd0, 14'h1FFF, 14'h1FFF);
      send_vertex(16'd16384, 14'h2000, 14'h1FFF);
      send_vertex(16'd32768, 14'h1FFF, 14'h2000);
      send_vertex(16'hFFFE, 14'h2000, 14'h2000);
      send_vertex(16'hFFFF, 14'h0000, 14'h1FFF);

      write_all(16'd1, MODE_LINEAR, 13'h1000, 13'h1000, 16'h8000, 16'h8000, 9'h101,
                32'hFFFF0000);
      send_vertex(16'd0, 14'h1FFF, 14'h2000);
      send_vertex(16'd1, 14'h2000, 14'h1FFF);

      write_all(16'd3000, MODE_NONE, 13'h0FFF, 13'h0FFF, 16'h7FFF, 16'h7FFF, 9'h0FF,
                32'h12345678);
      send_vertex(16'd0, 14'h1FFF, 14'h1FFF);
      send_vertex(16'd1500, 14'h2000, 14'h2000);

      for (int phase = 0; phase < 13; phase++) begin
         write_all(16'(pick(32'd1, 32'hFFFF, 16)), 2'(pick(MODE_LINEAR, MODE_COSINE, 2)),
                   13'(pick(32'h1000, 32'h0FFF, 13)), 13'(pick(32'h1000, 32'h0FFF, 13)),
                   16'(pick(32'h8000, 32'h7FFF, 16)), 16'(pick(32'h8000, 32'h7FFF, 16)),
                   9'(pick(32'h101, 32'h0FF, 9)), pick(32'h0, 32'hFFFFFFFF, 32));
         send_fast = ($urandom_range(0, 3) == 0);
         dur = u_checker.duration_r;
         count = 150;
         for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
               0: el = 16'($urandom);
               1: el = 16'(dur + $urandom_range(0, 3));
               default: el = 16'($urandom_range(0, dur));
            endcase
            send_vertex(el, 14'($urandom), 14'($urandom));
         end
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/esvt_pkg.sv
rtl/esvt_sin.sv
rtl/eased_sprite_vertex_transform.sv
tb/sv/esvt_checker.sv
tb/sv/tb_top.sv
